// ===== design/pcx_rle_scanline_decoder_top_macros.svh =====
// Assertion helpers for the decoder back end (pcx_back).
`ifndef PCX_RLE_SCANLINE_DECODER_TOP_MACROS_SVH
`define PCX_RLE_SCANLINE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pcx assertion failed");

// Next-cycle implication, checked out of reset.
`define PCX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcx assertion failed");

`endif

// ===== design/pcx_pkg.sv =====
package pcx_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PIXEL_MODE     = 3'd0,
    CFG_RLE_ENABLED    = 3'd1,
    CFG_BYTES_PER_LINE = 3'd2,
    CFG_IMAGE_WIDTH    = 3'd3,
    CFG_IMAGE_HEIGHT   = 3'd4
  } cfg_idx_e;

  // Pixel modes; code 3 is undefined and gives no results
  typedef enum logic [1:0] {
    MODE_MONO    = 2'd0,
    MODE_INDEXED = 2'd1,
    MODE_PLANAR  = 2'd2
  } pix_mode_e;

  // Input item function codes
  typedef enum logic {
    FUNC_PALETTE = 1'b0,
    FUNC_STREAM  = 1'b1
  } func_e;

  // Command kinds passed from front to back
  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_BYTES   = 1'b1
  } cmd_kind_e;

  localparam int unsigned CfgDataW  = 13;
  localparam logic [7:0]  RUN_MARK   = 8'hC0;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  typedef struct packed {
    logic        func;
    logic [7:0]  stream_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } pcx_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  mono_bits;
    logic [3:0]  mono_count;
    logic [11:0] column;
    logic [11:0] row;
    logic        end_of_row;
    logic        end_of_image;
    logic        last_of_run;
  } pcx_out_t;

  typedef struct packed {
    logic [1:0]  pixel_mode;
    logic        rle_enabled;
    logic [12:0] bytes_per_line;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  value;
    logic [5:0]  count;
    logic [7:0]  pal_index;
    logic [23:0] pal_color;
  } cmd_t;

endpackage

// ===== design/pcx_rle_scanline_decoder_top.sv =====
// PCX scanline decoder with run-length expansion.
// Input channel: an item (palette write or stream byte) is taken on a clock
// edge with push high and full low. Result channel: while empty is low the
// oldest result is on out_item_o; it leaves on an edge with pop high.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// write only while no item is in flight.
// Throughput: one decoded byte per cycle while the result queue has room. A
// literal byte gives one decoded byte and a run of n bytes gives n in the back
// sequencer; the count byte of a pair gives none. The back sequencer sets
// this rate; input stalls through full once the command queue fills.
// Path: an item passes the command queue, the stage register, the hold register
// and the result queue; an earlier run still expanding holds it back.
// Each result waits in a hold register until the next result or the end of
// its item is known, so it can carry last_of_run.
// Reset clears position, run state and queues; palette and line stores
// hold garbage until written. When the receiver stops popping, the result
// queue fills, the sequencer stops, then the command queue fills and full
// rises; nothing is dropped.
module pcx_rle_scanline_decoder_top #(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  pcx_pkg::pcx_in_t                in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output pcx_pkg::pcx_out_t               out_item_o,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [pcx_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned MaxW   = MAX_WIDTH;
  localparam int unsigned CmdW   = $bits(pcx_pkg::cmd_t);
  localparam int unsigned OutW   = $bits(pcx_pkg::pcx_out_t);

  pcx_pkg::cfg_t     cfg_q;
  pcx_pkg::cmd_t     cmd_wr, cmd_head;
  pcx_pkg::pcx_out_t out_wr;
  logic [CmdW-1:0]   cmd_rdata;
  logic [OutW-1:0]   out_rdata;
  logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic              out_push, out_full;

  // Clamp a line length into 1..MAX_WIDTH
  function automatic logic [12:0] clamp_width(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (32'(v) > MaxW) begin
      r = 13'(MaxW);
    end
    return r;
  endfunction

  // Clamp a height into 1..4096
  function automatic logic [12:0] clamp_height(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > pcx_pkg::MAX_HEIGHT) begin
      r = pcx_pkg::MAX_HEIGHT;
    end
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode     <= pcx_pkg::MODE_INDEXED;
      cfg_q.rle_enabled    <= 1'b1;
      cfg_q.bytes_per_line <= 13'd1;
      cfg_q.image_width    <= 13'd1;
      cfg_q.image_height   <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcx_pkg::CFG_PIXEL_MODE:     cfg_q.pixel_mode     <= cfg_data_i[1:0];
        pcx_pkg::CFG_RLE_ENABLED:    cfg_q.rle_enabled    <= cfg_data_i[0];
        pcx_pkg::CFG_BYTES_PER_LINE: cfg_q.bytes_per_line <= clamp_width(cfg_data_i);
        pcx_pkg::CFG_IMAGE_WIDTH:    cfg_q.image_width    <= clamp_width(cfg_data_i);
        pcx_pkg::CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= clamp_height(cfg_data_i);
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  pcx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .in_item_i    (in_item_i),
    .rle_enabled_i(cfg_q.rle_enabled),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_wr),
    .cmd_full_i   (cmd_full)
  );

  pcx_fifo #(
    .WIDTH(CmdW),
    .DEPTH(4)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wr),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  assign cmd_head = pcx_pkg::cmd_t'(cmd_rdata);

  pcx_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd_head),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .out_push_o (out_push),
    .out_item_o (out_wr),
    .out_full_i (out_full)
  );

  pcx_fifo #(
    .WIDTH(OutW),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wr),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign out_item_o = pcx_pkg::pcx_out_t'(out_rdata);

endmodule

// ===== design/pcx_fifo.sv =====
module pcx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Store the item at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ===== design/pcx_front.sv =====
module pcx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  pcx_pkg::pcx_in_t  in_item_i,
  input  logic              rle_enabled_i,
  output logic              cmd_push_o,
  output pcx_pkg::cmd_t     cmd_o,
  input  logic              cmd_full_i
);

  logic       accept;
  logic       is_mark;
  logic       awaiting_q, awaiting_d;
  logic [5:0] run_left_q, run_left_d;

  assign full_o  = cmd_full_i;
  assign accept  = push_i && !cmd_full_i;
  assign is_mark = (in_item_i.stream_byte >= pcx_pkg::RUN_MARK);

  // Classify the item: palette write, literal byte, run count or run value
  always_comb begin
    awaiting_d      = awaiting_q;
    run_left_d      = run_left_q;
    cmd_push_o      = 1'b0;
    cmd_o.kind      = pcx_pkg::CMD_BYTES;
    cmd_o.value     = in_item_i.stream_byte;
    cmd_o.count     = 6'd1;
    cmd_o.pal_index = in_item_i.palette_index;
    cmd_o.pal_color = in_item_i.palette_color;
    if (accept) begin
      if (in_item_i.func == pcx_pkg::FUNC_PALETTE) begin
        cmd_o.kind = pcx_pkg::CMD_PALETTE;
        cmd_push_o = 1'b1;
      end else if (!rle_enabled_i) begin
        cmd_push_o = 1'b1;
      end else if (awaiting_q) begin
        // value byte of a pair; an empty count drops the pair
        awaiting_d  = 1'b0;
        run_left_d  = 6'd0;
        cmd_o.count = run_left_q;
        cmd_push_o  = (run_left_q != 6'd0);
      end else if (is_mark) begin
        run_left_d = in_item_i.stream_byte[5:0];
        awaiting_d = 1'b1;
      end else begin
        cmd_push_o = 1'b1;
      end
    end
  end

  // Hold the pending run count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      run_left_q <= 6'd0;
    end else begin
      awaiting_q <= awaiting_d;
      run_left_q <= run_left_d;
    end
  end

endmodule

// ===== design/pcx_back.sv =====
`include "pcx_rle_scanline_decoder_top_macros.svh"

module pcx_back #(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcx_pkg::cfg_t     cfg_i,
  input  pcx_pkg::cmd_t     cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic              out_push_o,
  output pcx_pkg::pcx_out_t out_item_o,
  input  logic              out_full_i
);

  localparam int unsigned PW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PAW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned EW  = (PW + 4 > 14) ? PW + 4 : 14;

  typedef struct packed {
    logic        has_res;
    logic        last_rep;
    logic [1:0]  mode;
    logic        pal_oor;
    logic [7:0]  value;
    logic [7:0]  mono_bits;
    logic [3:0]  mono_count;
    logic [11:0] column;
    logic [11:0] row;
    logic        eor;
    logic        eoi;
  } stage_t;

  // Sequencer state
  logic [5:0]    rep_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [1:0]    plane_q, plane_d;
  logic [11:0]   scan_q, scan_d;
  logic          s1_v_q;
  stage_t        s1_q, s1_d;

  // Memories and their read registers
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [7:0]  red_mem [MAX_WIDTH];
  logic [7:0]  green_mem [MAX_WIDTH];
  logic [23:0] pal_rd_q;
  logic [7:0]  red_rd_q, green_rd_q;

  // Result hold register
  pcx_pkg::pcx_out_t pend_q, pend_d, res;
  logic              pend_v_q, pend_v_d, pend_final_q, pend_final_d;

  logic          a_go, b_take, head_v, byte_go, pal_we, rep_last;
  logic          line_end, last_line, plane_wrap, is_planar;
  logic [EW-1:0] pos_e, bpl_e, w_e, first_e, mono_left;
  logic [3:0]    mono_cnt;
  logic [7:0]    mono_mask;

  assign head_v    = !cmd_empty_i;
  assign a_go      = !s1_v_q || b_take;
  assign rep_last  = ((rep_q + 6'd1) == cmd_i.count);
  assign byte_go   = a_go && head_v && (cmd_i.kind == pcx_pkg::CMD_BYTES);
  assign pal_we    = a_go && head_v && (cmd_i.kind == pcx_pkg::CMD_PALETTE) &&
                     ({1'b0, cmd_i.pal_index} < 9'(PALETTE_ENTRIES));
  assign cmd_pop_o = a_go && head_v && ((cmd_i.kind == pcx_pkg::CMD_PALETTE) || rep_last);

  // Position arithmetic for the current decoded byte
  assign pos_e      = EW'(pos_q);
  assign bpl_e      = EW'(cfg_i.bytes_per_line);
  assign w_e        = EW'(cfg_i.image_width);
  assign first_e    = pos_e << 3;
  assign line_end   = ((pos_e + EW'(1)) >= bpl_e);
  assign last_line  = (({1'b0, scan_q} + 13'd1) >= cfg_i.image_height);
  assign is_planar  = (cfg_i.pixel_mode == pcx_pkg::MODE_PLANAR);
  assign plane_wrap = !is_planar || (plane_q >= 2'd2);
  assign mono_left  = w_e - first_e;
  assign mono_cnt   = (mono_left > EW'(8)) ? 4'd8 : 4'(mono_left);
  assign mono_mask  = 8'(8'hFF << (4'd8 - mono_cnt));

  // Build the stage record for one decoded byte
  always_comb begin
    s1_d            = '0;
    s1_d.last_rep   = rep_last;
    s1_d.mode       = cfg_i.pixel_mode;
    s1_d.value      = cmd_i.value;
    s1_d.pal_oor    = ({1'b0, cmd_i.value} >= 9'(PALETTE_ENTRIES));
    s1_d.row        = 12'(cfg_i.image_height - 13'd1 - {1'b0, scan_q});
    s1_d.column     = 12'(pos_q);
    unique case (cfg_i.pixel_mode)
      pcx_pkg::MODE_MONO: begin
        s1_d.has_res    = (first_e < w_e);
        s1_d.eor        = line_end || ((first_e + EW'(8)) >= w_e);
        s1_d.column     = 12'(first_e);
        s1_d.mono_bits  = cmd_i.value & mono_mask;
        s1_d.mono_count = mono_cnt;
      end
      pcx_pkg::MODE_INDEXED: begin
        s1_d.has_res = (pos_e < w_e);
        s1_d.eor     = line_end || ((pos_e + EW'(1)) >= w_e);
      end
      pcx_pkg::MODE_PLANAR: begin
        s1_d.has_res = (plane_q == 2'd2) && (pos_e < w_e);
        s1_d.eor     = line_end || ((pos_e + EW'(1)) >= w_e);
      end
      default: begin
        s1_d.has_res = 1'b0;
      end
    endcase
    s1_d.eoi = s1_d.eor && last_line;
  end

  // Next position, plane and scanline
  always_comb begin
    pos_d   = pos_q + PW'(1);
    plane_d = plane_q;
    scan_d  = scan_q;
    if (line_end) begin
      pos_d = '0;
      if (plane_wrap) begin
        plane_d = 2'd0;
        scan_d  = last_line ? 12'd0 : scan_q + 12'd1;
      end else begin
        plane_d = plane_q + 2'd1;
      end
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q   <= 6'd0;
      pos_q   <= '0;
      plane_q <= 2'd0;
      scan_q  <= 12'd0;
      s1_v_q  <= 1'b0;
    end else begin
      if (a_go) begin
        s1_v_q <= byte_go;
      end
      if (byte_go) begin
        rep_q   <= rep_last ? 6'd0 : rep_q + 6'd1;
        pos_q   <= pos_d;
        plane_q <= plane_d;
        scan_q  <= scan_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      s1_q <= s1_d;
    end
  end

  // Palette memory
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.pal_index[PAW-1:0]] <= cmd_i.pal_color;
    end
    if (a_go) begin
      pal_rd_q <= pal_mem[cmd_i.value[PAW-1:0]];
    end
  end

  // Red and green line stores
  always_ff @(posedge clk_i) begin
    if (byte_go && is_planar && (plane_q == 2'd0)) begin
      red_mem[pos_q] <= cmd_i.value;
    end
    if (byte_go && is_planar && (plane_q == 2'd1)) begin
      green_mem[pos_q] <= cmd_i.value;
    end
    if (a_go) begin
      red_rd_q   <= red_mem[pos_q];
      green_rd_q <= green_mem[pos_q];
    end
  end

  // Assemble the result from the stage record and read data
  always_comb begin
    res              = '0;
    res.mono_bits    = s1_q.mono_bits;
    res.mono_count   = s1_q.mono_count;
    res.column       = s1_q.column;
    res.row          = s1_q.row;
    res.end_of_row   = s1_q.eor;
    res.end_of_image = s1_q.eoi;
    case (s1_q.mode)
      pcx_pkg::MODE_INDEXED: begin
        if (!s1_q.pal_oor) begin
          res.red   = pal_rd_q[23:16];
          res.green = pal_rd_q[15:8];
          res.blue  = pal_rd_q[7:0];
        end
      end
      pcx_pkg::MODE_PLANAR: begin
        res.red   = red_rd_q;
        res.green = green_rd_q;
        res.blue  = s1_q.value;
      end
      default: begin
        res.red = 8'd0;
      end
    endcase
  end

  // Hold one result back so the last one of an item can be marked
  assign b_take = s1_v_q && !out_full_i;

  always_comb begin
    pend_d                 = pend_q;
    pend_v_d               = pend_v_q;
    pend_final_d           = pend_final_q;
    out_push_o             = 1'b0;
    out_item_o             = pend_q;
    out_item_o.last_of_run = 1'b0;
    if (!out_full_i) begin
      if (pend_v_q && pend_final_q) begin
        out_push_o             = 1'b1;
        out_item_o.last_of_run = 1'b1;
        pend_v_d               = 1'b0;
        pend_final_d           = 1'b0;
      end
      if (s1_v_q) begin
        if (s1_q.has_res) begin
          if (pend_v_q && !pend_final_q) begin
            out_push_o = 1'b1;
          end
          pend_d       = res;
          pend_v_d     = 1'b1;
          pend_final_d = s1_q.last_rep;
        end else if (s1_q.last_rep && pend_v_q && !pend_final_q) begin
          out_push_o             = 1'b1;
          out_item_o.last_of_run = 1'b1;
          pend_v_d               = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q     <= 1'b0;
      pend_final_q <= 1'b0;
    end else begin
      pend_v_q     <= pend_v_d;
      pend_final_q <= pend_final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  `PCX_ASSERT_IMPL(a_push_has_room, clk_i, rst_ni, out_push_o, !out_full_i)
  `PCX_ASSERT_IMPL(a_final_leaves, clk_i, rst_ni, pend_v_q && pend_final_q && !out_full_i, out_push_o)
  `PCX_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, b_take && s1_q.last_rep && !s1_q.has_res, !pend_v_q)
  `PCX_ASSERT_IMPL(a_rep_in_range, clk_i, rst_ni, head_v && cmd_i.kind == pcx_pkg::CMD_BYTES, rep_q < cmd_i.count)

endmodule

// ===== test/tb_pcx_rle_scanline_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_pcx_rle_scanline_decoder_top;

  localparam int unsigned MaxWidth       = 4096;
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned MaxRows        = 4096;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned DrainCycles    = 320;
  localparam int unsigned StallLimit     = 5000;
  localparam int unsigned PrintLimit     = 100;
  localparam logic [1:0]  ModeUndefined  = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              push = 1'b0;
  logic              full;
  pcx_pkg::pcx_in_t  in_item = '0;
  logic              empty;
  logic              pop = 1'b0;
  pcx_pkg::pcx_out_t out_item;
  logic                         cfg_we = 1'b0;
  logic [2:0]                   cfg_idx = '0;
  logic [pcx_pkg::CfgDataW-1:0] cfg_data = '0;

  pcx_rle_scanline_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copies, reset values
  logic [1:0]  cfg_mode   = pcx_pkg::MODE_INDEXED;
  logic        cfg_rle    = 1'b1;
  logic [12:0] cfg_bpl    = 13'd1;
  logic [12:0] cfg_width  = 13'd1;
  logic [12:0] cfg_height = 13'd1;

  // Decoder state mirror
  logic [5:0]  run_count     = '0;
  logic        count_pending = 1'b0;
  int unsigned line_pos      = 0;
  int unsigned plane_idx     = 0;
  int unsigned scanline_idx  = 0;
  logic [23:0] palette_copy [PaletteEntries];
  logic [7:0]  red_line     [MaxWidth];
  logic [7:0]  green_line   [MaxWidth];

  pcx_pkg::pcx_in_t  stim_items_q [$];
  pcx_pkg::pcx_out_t pixel_expect_q [$];
  logic [7:0]        pal_written_idx [$];

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned fault_count   = 0;
  int unsigned pixels_seen   = 0;
  int unsigned stall_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_reg(logic [12:0] v, int unsigned hi);
    if (v == '0) return 1;
    return (32'(v) > hi) ? hi : 32'(v);
  endfunction

  task automatic report_fault(string msg);
    if (fault_count < PrintLimit) $display("MISMATCH at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic emit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] mbits,
                            logic [3:0] mcount, logic [11:0] col, logic [11:0] row_num,
                            logic eor, logic eoi);
    pcx_pkg::pcx_out_t px;
    px.red          = r;
    px.green        = g;
    px.blue         = b;
    px.mono_bits    = mbits;
    px.mono_count   = mcount;
    px.column       = col;
    px.row          = row_num;
    px.end_of_row   = eor;
    px.end_of_image = eoi;
    px.last_of_run  = 1'b0;
    pixel_expect_q.insert(pixel_expect_q.size(), px);
  endtask

  // Place one decoded byte into the current scanline and advance the position
  task automatic place_byte(logic [7:0] d);
    int unsigned bpl, w, h, planes, pos, first, cnt, rowv;
    logic [7:0]  bits;
    logic [23:0] c;
    logic        last_line, line_end, eor;
    bpl       = clamp_reg(cfg_bpl, MaxWidth);
    w         = clamp_reg(cfg_width, MaxWidth);
    h         = clamp_reg(cfg_height, MaxRows);
    planes    = (cfg_mode == pcx_pkg::MODE_PLANAR) ? 3 : 1;
    pos       = line_pos;
    rowv      = (h - 1 - scanline_idx) & 32'hFFF;
    last_line = (scanline_idx + 1 >= h);
    line_end  = (pos + 1 >= bpl);
    case (cfg_mode)
      pcx_pkg::MODE_MONO: begin
        first = pos * 8;
        if (first < w) begin
          cnt  = (w - first > 8) ? 8 : w - first;
          bits = d & (8'hFF << (8 - cnt));
          eor  = line_end || (first + 8 >= w);
          emit_pixel('0, '0, '0, bits, 4'(cnt), 12'(first), 12'(rowv), eor, eor && last_line);
        end
      end
      pcx_pkg::MODE_INDEXED: begin
        if (pos < w) begin
          c   = palette_copy[d];
          eor = line_end || (pos + 1 >= w);
          emit_pixel(c[23:16], c[15:8], c[7:0], '0, '0, 12'(pos), 12'(rowv), eor,
                     eor && last_line);
        end
      end
      pcx_pkg::MODE_PLANAR: begin
        if (plane_idx == 0) begin
          red_line[pos] = d;
        end else if (plane_idx == 1) begin
          green_line[pos] = d;
        end else if (pos < w) begin
          eor = line_end || (pos + 1 >= w);
          emit_pixel(red_line[pos], green_line[pos], d, '0, '0, 12'(pos), 12'(rowv), eor,
                     eor && last_line);
        end
      end
      default: begin
      end
    endcase
    if (line_end) begin
      line_pos = 0;
      if (plane_idx + 1 >= planes) begin
        plane_idx    = 0;
        scanline_idx = last_line ? 0 : scanline_idx + 1;
      end else begin
        plane_idx++;
      end
    end else begin
      line_pos = pos + 1;
    end
  endtask

  // Work out the pixels one accepted item produces
  task automatic decode_item(pcx_pkg::pcx_in_t item);
    int unsigned       k;
    int unsigned       start_cnt;
    pcx_pkg::pcx_out_t tail;
    if (item.func == pcx_pkg::FUNC_PALETTE) begin
      palette_copy[item.palette_index] = item.palette_color;
      return;
    end
    start_cnt = pixel_expect_q.size();
    if (cfg_rle) begin
      if (count_pending) begin
        k             = run_count;
        count_pending = 1'b0;
        run_count     = '0;
        repeat (k) place_byte(item.stream_byte);
      end else if (item.stream_byte >= pcx_pkg::RUN_MARK) begin
        run_count     = 6'(item.stream_byte - pcx_pkg::RUN_MARK);
        count_pending = 1'b1;
      end else begin
        place_byte(item.stream_byte);
      end
    end else begin
      place_byte(item.stream_byte);
    end
    // Flag the last pixel of this item
    if (pixel_expect_q.size() > start_cnt) begin
      tail             = pixel_expect_q.pop_back();
      tail.last_of_run = 1'b1;
      pixel_expect_q.insert(pixel_expect_q.size(), tail);
    end
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_fault($sformatf("pixel %0d %s got %0h want %0h", pixels_seen, name, got, want));
  endtask

  task automatic check_pixel(pcx_pkg::pcx_out_t got);
    pcx_pkg::pcx_out_t want;
    if (pixel_expect_q.size() == 0) begin
      report_fault($sformatf("pixel %0d with none expected: %h", pixels_seen, got));
      pixels_seen++;
      return;
    end
    want = pixel_expect_q.pop_front();
    compare_field("red", 32'(got.red), 32'(want.red));
    compare_field("green", 32'(got.green), 32'(want.green));
    compare_field("blue", 32'(got.blue), 32'(want.blue));
    compare_field("mono_bits", 32'(got.mono_bits), 32'(want.mono_bits));
    compare_field("mono_count", 32'(got.mono_count), 32'(want.mono_count));
    compare_field("column", 32'(got.column), 32'(want.column));
    compare_field("row", 32'(got.row), 32'(want.row));
    compare_field("end_of_row", 32'(got.end_of_row), 32'(want.end_of_row));
    compare_field("end_of_image", 32'(got.end_of_image), 32'(want.end_of_image));
    compare_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    pixels_seen++;
  endtask

  // Driver: hold the offered item until taken, then load the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) decode_item(in_item);
      if (!push || !full) begin
        if (stim_items_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          push    <= 1'b1;
          in_item <= stim_items_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped pixel, stall pop at random or for a long hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_pixel(out_item);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_stream(logic [7:0] b);
    pcx_pkg::pcx_in_t it;
    it.func          = pcx_pkg::FUNC_STREAM;
    it.stream_byte   = b;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    stim_items_q.insert(stim_items_q.size(), it);
  endtask

  task automatic queue_palette(logic [7:0] idx, logic [23:0] color);
    pcx_pkg::pcx_in_t it;
    it.func          = pcx_pkg::FUNC_PALETTE;
    it.stream_byte   = 8'($urandom);
    it.palette_index = idx;
    it.palette_color = color;
    stim_items_q.insert(stim_items_q.size(), it);
    pal_written_idx.insert(pal_written_idx.size(), idx);
  endtask

  // Data bytes come from palette entries already written
  function automatic logic [7:0] pick_data();
    return pal_written_idx[$urandom_range(0, pal_written_idx.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_literal();
    logic [7:0] v;
    v = pick_data();
    while (v >= pcx_pkg::RUN_MARK) v = pick_data();
    return v;
  endfunction

  // Wait until every item is taken and every pixel has come, then let runs
  // that give no pixels drain out of the block
  task automatic settle();
    while (stim_items_q.size() != 0 || push || pixel_expect_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(pcx_pkg::cfg_idx_e idx, logic [12:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      pcx_pkg::CFG_PIXEL_MODE:     cfg_mode   = value[1:0];
      pcx_pkg::CFG_RLE_ENABLED:    cfg_rle    = value[0];
      pcx_pkg::CFG_BYTES_PER_LINE: cfg_bpl    = value;
      pcx_pkg::CFG_IMAGE_WIDTH:    cfg_width  = value;
      pcx_pkg::CFG_IMAGE_HEIGHT:   cfg_height = value;
      default: begin
      end
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Switch settings at idle; planar mode is entered only at the start of a line
  // so its plane stores are always filled before they are read
  task automatic configure(logic [1:0] mode, logic rle, logic [12:0] bpl, logic [12:0] w,
                           logic [12:0] h);
    settle();
    if (mode == pcx_pkg::MODE_PLANAR && (line_pos != 0 || plane_idx != 0)) begin
      write_reg(pcx_pkg::CFG_BYTES_PER_LINE, 13'd1);
      write_reg(pcx_pkg::CFG_RLE_ENABLED, 13'd0);
      while (line_pos != 0 || plane_idx != 0) begin
        queue_stream(8'h00);
        settle();
      end
    end
    write_reg(pcx_pkg::CFG_PIXEL_MODE, 13'(mode));
    write_reg(pcx_pkg::CFG_RLE_ENABLED, 13'(rle));
    write_reg(pcx_pkg::CFG_BYTES_PER_LINE, bpl);
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [12:0] pick_size(int unsigned typical_hi);
    case ($urandom_range(0, 39))
      0:       return 13'd0;
      1:       return 13'd4096;
      2:       return 13'd8191;
      3:       return 13'd4095;
      default: return 13'($urandom_range(1, typical_hi));
    endcase
  endfunction

  // Mostly well-formed count/value pairs, with stray bytes and palette writes
  task automatic queue_random_items(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_palette(8'($urandom), 24'($urandom));
        sent += 1;
      end else if (!cfg_rle) begin
        queue_stream(pick_data());
        sent += 1;
      end else if (pick < 12) begin
        queue_stream(pcx_pkg::RUN_MARK);
        queue_stream(pick_data());
        sent += 2;
      end else if (pick < 62) begin
        queue_stream(pcx_pkg::RUN_MARK + 8'($urandom_range(1, 63)));
        queue_stream(pick_data());
        sent += 2;
      end else if (pick < 72) begin
        // stray byte: may leave a count waiting or break a pair
        queue_stream(pick_data());
        sent += 1;
      end else begin
        queue_stream(pick_literal());
        sent += 1;
      end
    end
  endtask

  initial begin
    logic [1:0] mode;
    tx_idle_pct = 35;
    rx_idle_pct = 46;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Write every run-mark code, since a stray byte can turn one into a value,
    // and the data bytes used below
    for (int i = 0; i < 64; i++) queue_palette(pcx_pkg::RUN_MARK + 8'(i), 24'($urandom));
    queue_palette(8'h00, 24'($urandom));
    queue_palette(8'h12, 24'($urandom));
    queue_palette(8'h21, 24'($urandom));
    queue_palette(8'h42, 24'($urandom));
    queue_palette(8'h44, 24'($urandom));
    queue_palette(8'h80, 24'($urandom));
    queue_palette(8'hBF, 24'($urandom));
    repeat (9) queue_palette(8'($urandom_range(0, 191)), 24'($urandom));

    // Literal extremes, runs across a scanline and the image end, empty run
    configure(pcx_pkg::MODE_INDEXED, 1'b1, 13'd4, 13'd3, 13'd2);
    queue_stream(8'h00);
    queue_stream(8'hBF);
    queue_stream(8'hC5);
    queue_stream(8'hFF);
    queue_stream(pcx_pkg::RUN_MARK);
    queue_stream(8'h12);
    queue_stream(8'hFF);
    queue_stream(8'h80);
    // Count waits across a raw byte while decoding is off, then resumes
    queue_stream(8'hC3);
    settle();
    write_reg(pcx_pkg::CFG_RLE_ENABLED, 13'd0);
    queue_stream(8'hC7);
    settle();
    write_reg(pcx_pkg::CFG_RLE_ENABLED, 13'd1);
    queue_stream(8'h44);
    queue_palette(8'h00, 24'hFFFFFF);
    queue_palette(8'hFF, 24'h000000);
    settle();
    write_reg(pcx_pkg::CFG_RLE_ENABLED, 13'd0);
    queue_stream(8'hFF);
    queue_stream(8'h00);

    // Lower the height below the current scanline: row wraps
    configure(pcx_pkg::MODE_INDEXED, 1'b0, 13'd2, 13'd2, 13'd4);
    repeat (3) queue_stream(pick_data());
    configure(pcx_pkg::MODE_INDEXED, 1'b0, 13'd2, 13'd2, 13'd1);
    repeat (2) queue_stream(pick_data());

    // Mono: partial last byte, then a line shorter than the width
    configure(pcx_pkg::MODE_MONO, 1'b1, 13'd3, 13'd20, 13'd1);
    queue_stream(8'hFF);
    queue_stream(8'hA5);
    queue_stream(8'h5A);
    configure(pcx_pkg::MODE_MONO, 1'b0, 13'd3, 13'd30, 13'd1);
    queue_stream(8'h81);
    queue_stream(8'h7E);
    queue_stream(8'hFF);

    // Undefined mode, planar run over all three planes, register clamping
    configure(ModeUndefined, 1'b0, 13'd2, 13'd2, 13'd1);
    queue_stream(8'h11);
    configure(pcx_pkg::MODE_PLANAR, 1'b1, 13'd2, 13'd2, 13'd1);
    queue_stream(8'hC6);
    queue_stream(8'h9C);
    configure(pcx_pkg::MODE_INDEXED, 1'b0, 13'd0, 13'd0, 13'd0);
    queue_stream(8'h21);
    configure(pcx_pkg::MODE_INDEXED, 1'b0, 13'd8191, 13'd8191, 13'd8191);
    queue_stream(8'h42);

    // Back-pressure: hold pop while long runs keep coming
    configure(pcx_pkg::MODE_INDEXED, 1'b1, 13'd16, 13'd16, 13'd4);
    tx_idle_pct = 0;
    hold_requests++;
    repeat (20) begin
      queue_stream(8'hFF);
      queue_stream(pick_data());
    end

    // Random settings; idling shifts from receiver-heavy to sender-heavy to none
    for (int grp = 0; grp < 3; grp++) begin
      case (grp)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 46;
        end
        1: begin
          tx_idle_pct = 46;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        if ($urandom_range(0, 11) == 0) mode = ModeUndefined;
        else mode = 2'($urandom_range(0, 2));
        configure(mode, 1'($urandom_range(0, 3) != 0), pick_size(12), pick_size(24),
                  pick_size(4));
        queue_random_items(10);
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pcx_pkg.sv
design/pcx_fifo.sv
design/pcx_front.sv
design/pcx_back.sv
design/pcx_rle_scanline_decoder_top.sv
test/tb_pcx_rle_scanline_decoder_top.sv
